// File: hw/rtl/dihedral_angle_assert.svh
// Assertion macros used by the dihedral angle top module.
`ifndef DIHEDRAL_ANGLE_ASSERT_SVH
`define DIHEDRAL_ANGLE_ASSERT_SVH

// Checked on every clock, not while reset is high.
`define DHA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every clock, reset included.
`define DHA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hw/rtl/dha_pkg.sv
package dha_pkg;

   localparam int FRAC_BITS        = 16;
   localparam int CORDIC_STEPS     = 18;
   localparam int COORD_W          = 32;
   localparam int OUT_W            = 25;

   localparam int SQRT_STEPS       = 32;
   localparam int SQRT_PER_STAGE   = 2;
   localparam int SQRT_STAGES      = (SQRT_STEPS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;
   localparam int DIV_STEPS        = 31;
   localparam int DIV_PER_STAGE    = 4;
   localparam int DIV_STAGES       = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
   localparam int CORDIC_PER_STAGE = 2;
   localparam int CORDIC_STAGES    = (CORDIC_STEPS + CORDIC_PER_STAGE - 1) / CORDIC_PER_STAGE;

   // register stages from input transfer to the result register input
   localparam int PIPE_DEPTH = 17 + 2 * SQRT_STAGES + DIV_STAGES + CORDIC_STAGES;

   localparam int RAD_SH = 30 - FRAC_BITS;
   localparam int DEG_SH = 54 - FRAC_BITS;

   localparam logic signed [35:0] HALF_PI_Q30     = 36'sd1686629713;
   localparam logic        [29:0] DEG_PER_RAD_Q24 = 30'd961263669;
   localparam logic signed [67:0] OUT_MAX = (68'sd1 <<< (OUT_W - 1)) - 68'sd1;
   localparam logic signed [67:0] OUT_MIN = -(68'sd1 <<< (OUT_W - 1));

   typedef enum logic [1:0] {
      MODE_RAD     = 2'd0,
      MODE_DEG     = 2'd1,
      MODE_COS     = 2'd2,
      MODE_COS_ALT = 2'd3
   } mode_type;

   localparam mode_type MODE_RESET = MODE_DEG;

   typedef struct packed {
      logic       rsh;
      logic [5:0] amt;
   } scale_type;

   typedef struct packed {
      logic degen;
      logic neg;
   } side_type;

   typedef struct packed {
      side_type           side;
      logic signed [31:0] c;
   } cside_type;

   typedef struct packed {
      logic [63:0] n;
      logic [63:0] r;
   } sq_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [30:0] aq;
      logic [30:0] dv;
      logic        sg;
   } div_type;

   typedef struct packed {
      logic signed [35:0] x;
      logic signed [35:0] y;
      logic signed [35:0] z;
   } cor_type;

   // shift that brings the largest magnitude into [2^29, 2^30)
   function automatic scale_type scale_info(input logic [63:0] m);
      scale_type s;
      int        p;
      p = 0;
      for (int i = 0; i < 64; i++) begin
         if (m[i]) begin
            p = i;
         end
      end
      if (p >= 30) begin
         s.rsh = 1'b1;
         s.amt = 6'(p - 29);
      end else begin
         s.rsh = 1'b0;
         s.amt = 6'(29 - p);
      end
      return s;
   endfunction

   function automatic logic signed [31:0] scale_val(input logic signed [63:0] v,
                                                    input scale_type s);
      logic signed [63:0] t;
      t = s.rsh ? (v >>> s.amt) : (v <<< s.amt);
      return t[31:0];
   endfunction

   function automatic sq_type sqrt_step(input sq_type a, input int pos);
      sq_type      b;
      logic [63:0] bt;
      bt = 64'd1 << (2 * pos);
      if (a.n >= a.r + bt) begin
         b.n = a.n - (a.r + bt);
         b.r = (a.r >> 1) + bt;
      end else begin
         b.n = a.n;
         b.r = a.r >> 1;
      end
      return b;
   endfunction

   // restoring division, one quotient bit
   function automatic div_type div_step(input div_type a);
      div_type     b;
      logic [31:0] r2;
      b  = a;
      r2 = {a.rem[30:0], a.aq[30]};
      if (r2 >= {1'b0, a.dv}) begin
         b.rem = r2 - {1'b0, a.dv};
         b.aq  = {a.aq[29:0], 1'b1};
      end else begin
         b.rem = r2;
         b.aq  = {a.aq[29:0], 1'b0};
      end
      return b;
   endfunction

   // atan(2^-i) in Q30
   function automatic logic signed [35:0] atan_entry(input int i);
      logic signed [35:0] t;
      case (i)
         0:       t = 36'sd843314857;
         1:       t = 36'sd497837829;
         2:       t = 36'sd263043837;
         3:       t = 36'sd133525159;
         4:       t = 36'sd67021687;
         5:       t = 36'sd33543516;
         6:       t = 36'sd16775851;
         7:       t = 36'sd8388437;
         8:       t = 36'sd4194283;
         9:       t = 36'sd2097149;
         default: begin
            if (i <= 30) begin
               t = 36'sd1 <<< (30 - i);
            end else begin
               t = '0;
            end
         end
      endcase
      return t;
   endfunction

   function automatic cor_type cordic_step(input cor_type a, input int i);
      cor_type            b;
      logic signed [35:0] x;
      logic signed [35:0] y;
      logic signed [35:0] z;
      x = a.x;
      y = a.y;
      z = a.z;
      if (!y[35]) begin
         b.x = x + (y >>> i);
         b.y = y - (x >>> i);
         b.z = z + atan_entry(i);
      end else begin
         b.x = x - (y >>> i);
         b.y = y + (x >>> i);
         b.z = z - atan_entry(i);
      end
      return b;
   endfunction

   // add half, then floor shift
   function automatic logic signed [67:0] round_shift(input logic signed [67:0] v,
                                                      input int sh);
      return (v + (68'sd1 <<< (sh - 1))) >>> sh;
   endfunction

endpackage

// File: hw/rtl/dha_stream_if.sv
interface dha_req_if import dha_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [COORD_W-1:0]  p1_x;
   logic signed [COORD_W-1:0]  p1_y;
   logic signed [COORD_W-1:0]  p1_z;
   logic signed [COORD_W-1:0]  p2_x;
   logic signed [COORD_W-1:0]  p2_y;
   logic signed [COORD_W-1:0]  p2_z;
   logic signed [COORD_W-1:0]  p3_x;
   logic signed [COORD_W-1:0]  p3_y;
   logic signed [COORD_W-1:0]  p3_z;
   logic signed [COORD_W-1:0]  p4_x;
   logic signed [COORD_W-1:0]  p4_y;
   logic signed [COORD_W-1:0]  p4_z;

   modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                   p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, input ready);
   modport sink   (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                   p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, output ready);
endinterface

interface dha_rsp_if import dha_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [OUT_W-1:0]  angle_value;
   logic                     degenerate;

   modport source (output valid, angle_value, degenerate, input ready);
   modport sink   (input valid, angle_value, degenerate, output ready);
endinterface

// File: hw/rtl/dha_isqrt.sv
module dha_isqrt import dha_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [62:0] rad,
   output logic [31:0] root
);

   sq_type st_ff  [SQRT_STAGES];
   sq_type st_in  [SQRT_STAGES];
   sq_type st_src [SQRT_STAGES];

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign st_src[s] = '{n: {1'b0, rad}, r: '0};
      end else begin : g_next
         assign st_src[s] = st_ff[s-1];
      end

      always_comb begin
         sq_type t;
         t = st_src[s];
         for (int k = 0; k < SQRT_PER_STAGE; k++) begin
            if (s * SQRT_PER_STAGE + k < SQRT_STEPS) begin
               t = sqrt_step(t, SQRT_STEPS - 1 - (s * SQRT_PER_STAGE + k));
            end
         end
         st_in[s] = t;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   assign root = st_ff[SQRT_STAGES-1].r[31:0];

endmodule

// File: hw/rtl/dha_cordic.sv
module dha_cordic import dha_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  cor_type            start,
   output logic signed [35:0] angle
);

   cor_type cs_ff  [CORDIC_STAGES];
   cor_type cs_in  [CORDIC_STAGES];
   cor_type cs_src [CORDIC_STAGES];

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign cs_src[s] = start;
      end else begin : g_next
         assign cs_src[s] = cs_ff[s-1];
      end

      always_comb begin
         cor_type t;
         t = cs_src[s];
         for (int k = 0; k < CORDIC_PER_STAGE; k++) begin
            if (s * CORDIC_PER_STAGE + k < CORDIC_STEPS) begin
               t = cordic_step(t, s * CORDIC_PER_STAGE + k);
            end
         end
         cs_in[s] = t;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cs_ff[s] <= cs_in[s];
         end
      end
   end

   assign angle = cs_ff[CORDIC_STAGES-1].z;

endmodule

// File: hw/rtl/dihedral_angle.sv
// Dihedral (torsion) angle of four points, fully pipelined.
// Built from two 16-stage square root pipelines in series (normal lengths, then sine),
// an 8-stage divider and 9 CORDIC stages.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// Reset (synchronous, active high) clears all valid bits and sets the output mode to degrees.
`include "dihedral_angle_assert.svh"

module dihedral_angle import dha_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   dha_req_if.sink      req_if,
   dha_rsp_if.source    rsp_if,
   input  logic         csr_wen,
   input  logic [1:0]   csr_wdata
);

   logic                  en;
   mode_type              mode_ff;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic                  rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_value_ff;
   logic                  rsp_degen_ff;

   assign en           = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else if (csr_wen) begin
         mode_ff <= mode_type'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[PIPE_DEPTH-2:0], req_if.valid};
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   // ---------------- stage 1: differences AB, CB, DC
   logic signed [31:0] pt [4][3];
   logic signed [32:0] d1_in [3][3];
   logic signed [32:0] d1_ff [3][3];
   logic               zero1_in;
   logic               zero1_ff;

   always_comb begin
      pt[0][0] = req_if.p1_x;  pt[0][1] = req_if.p1_y;  pt[0][2] = req_if.p1_z;
      pt[1][0] = req_if.p2_x;  pt[1][1] = req_if.p2_y;  pt[1][2] = req_if.p2_z;
      pt[2][0] = req_if.p3_x;  pt[2][1] = req_if.p3_y;  pt[2][2] = req_if.p3_z;
      pt[3][0] = req_if.p4_x;  pt[3][1] = req_if.p4_y;  pt[3][2] = req_if.p4_z;
      zero1_in = 1'b0;
      for (int j = 0; j < 3; j++) begin
         d1_in[0][j] = 33'(pt[0][j]) - 33'(pt[1][j]);
         d1_in[1][j] = 33'(pt[2][j]) - 33'(pt[1][j]);
         d1_in[2][j] = 33'(pt[3][j]) - 33'(pt[2][j]);
      end
      for (int k = 0; k < 3; k++) begin
         if (d1_in[k][0] == '0 && d1_in[k][1] == '0 && d1_in[k][2] == '0) begin
            zero1_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff    <= d1_in;
         zero1_ff <= zero1_in;
      end
   end

   // ---------------- stage 2: block scale shift of the three vectors
   scale_type          sc2_in [3];
   scale_type          sc2_ff [3];
   logic signed [32:0] d2_ff  [3][3];
   logic               zero2_ff;

   always_comb begin
      logic [32:0] m;
      logic [32:0] mx;
      for (int k = 0; k < 3; k++) begin
         mx = '0;
         for (int j = 0; j < 3; j++) begin
            m = d1_ff[k][j][32] ? 33'(-d1_ff[k][j]) : 33'(d1_ff[k][j]);
            if (m > mx) begin
               mx = m;
            end
         end
         sc2_in[k] = scale_info({31'b0, mx});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sc2_ff   <= sc2_in;
         d2_ff    <= d1_ff;
         zero2_ff <= zero1_ff;
      end
   end

   // ---------------- stage 3: apply scaling
   logic signed [31:0] v3_in [3][3];
   logic signed [31:0] v3_ff [3][3];
   logic               zero3_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            v3_in[k][j] = scale_val(64'(d2_ff[k][j]), sc2_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v3_ff    <= v3_in;
         zero3_ff <= zero2_ff;
      end
   end

   // ---------------- stage 4: cross product terms, N1 = AB x CB, N2 = DC x CB
   logic signed [63:0] pp4_in [2][6];
   logic signed [63:0] pp4_ff [2][6];
   logic signed [31:0] dc4_ff [3];
   logic               zero4_ff;

   always_comb begin
      for (int v = 0; v < 2; v++) begin
         pp4_in[v][0] = v3_ff[2*v][1] * v3_ff[1][2];
         pp4_in[v][1] = v3_ff[2*v][2] * v3_ff[1][1];
         pp4_in[v][2] = v3_ff[2*v][2] * v3_ff[1][0];
         pp4_in[v][3] = v3_ff[2*v][0] * v3_ff[1][2];
         pp4_in[v][4] = v3_ff[2*v][0] * v3_ff[1][1];
         pp4_in[v][5] = v3_ff[2*v][1] * v3_ff[1][0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp4_ff   <= pp4_in;
         dc4_ff   <= v3_ff[2];
         zero4_ff <= zero3_ff;
      end
   end

   // ---------------- stage 5: normals
   logic signed [63:0] n5_in [2][3];
   logic signed [63:0] n5_ff [2][3];
   logic signed [31:0] dc5_ff [3];
   logic               zero5_ff;

   always_comb begin
      for (int v = 0; v < 2; v++) begin
         for (int j = 0; j < 3; j++) begin
            n5_in[v][j] = pp4_ff[v][2*j] - pp4_ff[v][2*j+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n5_ff    <= n5_in;
         dc5_ff   <= dc4_ff;
         zero5_ff <= zero4_ff;
      end
   end

   // ---------------- stage 6: collinear check and normal scale shift
   scale_type          sc6_in [2];
   scale_type          sc6_ff [2];
   logic signed [63:0] n6_ff  [2][3];
   logic signed [31:0] dc6_ff [3];
   logic               degen6_in;
   logic               degen6_ff;

   always_comb begin
      logic [63:0] m;
      logic [63:0] mx;
      degen6_in = zero5_ff;
      for (int v = 0; v < 2; v++) begin
         mx = '0;
         for (int j = 0; j < 3; j++) begin
            m = n5_ff[v][j][63] ? 64'(-n5_ff[v][j]) : 64'(n5_ff[v][j]);
            if (m > mx) begin
               mx = m;
            end
         end
         if (mx == '0) begin
            degen6_in = 1'b1;
         end
         sc6_in[v] = scale_info(mx);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sc6_ff    <= sc6_in;
         n6_ff     <= n5_ff;
         dc6_ff    <= dc5_ff;
         degen6_ff <= degen6_in;
      end
   end

   // ---------------- stage 7: scaled normals
   logic signed [31:0] ns7_in [2][3];
   logic signed [31:0] ns7_ff [2][3];
   logic signed [31:0] dc7_ff [3];
   logic               degen7_ff;

   always_comb begin
      for (int v = 0; v < 2; v++) begin
         for (int j = 0; j < 3; j++) begin
            ns7_in[v][j] = scale_val(n6_ff[v][j], sc6_ff[v]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ns7_ff    <= ns7_in;
         dc7_ff    <= dc6_ff;
         degen7_ff <= degen6_ff;
      end
   end

   // ---------------- stage 8: squares and N1 . DC terms
   logic signed [63:0] sq8_in  [2][3];
   logic signed [63:0] sq8_ff  [2][3];
   logic signed [63:0] ndc8_in [3];
   logic signed [63:0] ndc8_ff [3];
   logic signed [31:0] ns8_ff  [2][3];
   logic               degen8_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sq8_in[0][j] = ns7_ff[0][j] * ns7_ff[0][j];
         sq8_in[1][j] = ns7_ff[1][j] * ns7_ff[1][j];
         ndc8_in[j]   = ns7_ff[0][j] * dc7_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq8_ff    <= sq8_in;
         ndc8_ff   <= ndc8_in;
         ns8_ff    <= ns7_ff;
         degen8_ff <= degen7_ff;
      end
   end

   // ---------------- stage 9: squared lengths and torsion sign
   logic [62:0]        rad9_in [2];
   logic [62:0]        rad9_ff [2];
   logic signed [31:0] ns9_ff  [2][3];
   side_type           side9_in;
   side_type           side9_ff;

   always_comb begin
      logic [63:0]        s;
      logic signed [65:0] d;
      for (int v = 0; v < 2; v++) begin
         s          = 64'(sq8_ff[v][0]) + 64'(sq8_ff[v][1]) + 64'(sq8_ff[v][2]);
         rad9_in[v] = s[62:0];
      end
      d              = 66'(ndc8_ff[0]) + 66'(ndc8_ff[1]) + 66'(ndc8_ff[2]);
      side9_in.degen = degen8_ff;
      side9_in.neg   = d > 66'sd0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad9_ff  <= rad9_in;
         ns9_ff   <= ns8_ff;
         side9_ff <= side9_in;
      end
   end

   // ---------------- normal lengths
   logic [31:0] len_root [2];

   dha_isqrt u_len0 (.clock(clock), .en(en), .rad(rad9_ff[0]), .root(len_root[0]));
   dha_isqrt u_len1 (.clock(clock), .en(en), .rad(rad9_ff[1]), .root(len_root[1]));

   logic signed [31:0] nsd_ff [SQRT_STAGES][2][3];
   side_type           sd_ff  [SQRT_STAGES + DIV_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         nsd_ff[0] <= ns9_ff;
         for (int s = 1; s < SQRT_STAGES; s++) begin
            nsd_ff[s] <= nsd_ff[s-1];
         end
         sd_ff[0] <= side9_ff;
         for (int s = 1; s < SQRT_STAGES + DIV_STAGES; s++) begin
            sd_ff[s] <= sd_ff[s-1];
         end
      end
   end

   // ---------------- unit vectors: |n| * 2^30 / len, six dividers
   div_type dv_setup [6];
   div_type dv_src   [DIV_STAGES][6];
   div_type dv_in    [DIV_STAGES][6];
   div_type dv_ff    [DIV_STAGES][6];

   always_comb begin
      logic signed [31:0] v;
      logic [31:0]        m;
      for (int c = 0; c < 6; c++) begin
         v               = nsd_ff[SQRT_STAGES-1][c/3][c%3];
         m               = v[31] ? 32'(-v) : 32'(v);
         dv_setup[c].rem = {2'b0, m[30:1]};
         dv_setup[c].aq  = {m[0], 30'b0};
         dv_setup[c].dv  = len_root[c/3][30:0];
         dv_setup[c].sg  = v[31];
      end
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      for (genvar c = 0; c < 6; c++) begin : g_lane
         if (s == 0) begin : g_first
            assign dv_src[s][c] = dv_setup[c];
         end else begin : g_next
            assign dv_src[s][c] = dv_ff[s-1][c];
         end

         always_comb begin
            div_type t;
            t = dv_src[s][c];
            for (int k = 0; k < DIV_PER_STAGE; k++) begin
               if (s * DIV_PER_STAGE + k < DIV_STEPS) begin
                  t = div_step(t);
               end
            end
            dv_in[s][c] = t;
         end

         always_ff @(posedge clock) begin
            if (en) begin
               dv_ff[s][c] <= dv_in[s][c];
            end
         end
      end
   end

   // ---------------- cosine: dot of unit vectors
   logic [61:0]        uu1_ff [3];
   logic               usg1_ff [3];
   logic signed [63:0] term2_ff [3];
   logic signed [31:0] c3_in;
   logic signed [31:0] c3_ff;
   logic [61:0]        cc4_ff;
   logic signed [31:0] c4_ff;
   logic [62:0]        srad5_ff;
   logic signed [31:0] c5_ff;
   side_type           sp_ff [5];

   always_comb begin
      logic signed [63:0] sum;
      logic signed [63:0] sh;
      sum = term2_ff[0] + term2_ff[1] + term2_ff[2];
      sh  = sum >>> 30;
      if (sh > 64'sd1073741824) begin
         c3_in = 32'sd1073741824;
      end else if (sh < -64'sd1073741824) begin
         c3_in = -32'sd1073741824;
      end else begin
         c3_in = sh[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            uu1_ff[j]   <= 62'(dv_ff[DIV_STAGES-1][j].aq) *
                           62'(dv_ff[DIV_STAGES-1][j+3].aq);
            usg1_ff[j]  <= dv_ff[DIV_STAGES-1][j].sg ^ dv_ff[DIV_STAGES-1][j+3].sg;
            term2_ff[j] <= usg1_ff[j] ? -$signed({2'b0, uu1_ff[j]})
                                      : $signed({2'b0, uu1_ff[j]});
         end
         c3_ff    <= c3_in;
         cc4_ff   <= 62'(c3_ff * c3_ff);
         c4_ff    <= c3_ff;
         srad5_ff <= (63'd1 << 60) - {1'b0, cc4_ff};
         c5_ff    <= c4_ff;
         sp_ff[0] <= sd_ff[SQRT_STAGES+DIV_STAGES-1];
         for (int s = 1; s < 5; s++) begin
            sp_ff[s] <= sp_ff[s-1];
         end
      end
   end

   // ---------------- sine, then arccosine by CORDIC
   logic [31:0] sin_root;
   cside_type   cs_ff [SQRT_STAGES];

   dha_isqrt u_sin (.clock(clock), .en(en), .rad(srad5_ff), .root(sin_root));

   always_ff @(posedge clock) begin
      if (en) begin
         cs_ff[0] <= '{side: sp_ff[4], c: c5_ff};
         for (int s = 1; s < SQRT_STAGES; s++) begin
            cs_ff[s] <= cs_ff[s-1];
         end
      end
   end

   cor_type   ci_in;
   cor_type   ci_ff;
   cside_type cci_ff;

   // negative cosine starts a quarter turn on
   always_comb begin
      logic signed [31:0] c;
      c = cs_ff[SQRT_STAGES-1].c;
      if (c[31]) begin
         ci_in.x = $signed(36'(sin_root));
         ci_in.y = -36'(c);
         ci_in.z = HALF_PI_Q30;
      end else begin
         ci_in.x = 36'(c);
         ci_in.y = $signed(36'(sin_root));
         ci_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ci_ff  <= ci_in;
         cci_ff <= cs_ff[SQRT_STAGES-1];
      end
   end

   logic signed [35:0] theta;
   cside_type          ccd_ff [CORDIC_STAGES];

   dha_cordic u_cordic (.clock(clock), .en(en), .start(ci_ff), .angle(theta));

   always_ff @(posedge clock) begin
      if (en) begin
         ccd_ff[0] <= cci_ff;
         for (int s = 1; s < CORDIC_STAGES; s++) begin
            ccd_ff[s] <= ccd_ff[s-1];
         end
      end
   end

   // ---------------- degrees: theta * 180/pi split in two partial products
   logic [46:0]        prlo1_ff;
   logic signed [49:0] prhi1_ff;
   logic signed [35:0] th1_ff;
   cside_type          co1_ff;
   logic signed [67:0] deg2_ff;
   logic signed [35:0] th2_ff;
   cside_type          co2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prlo1_ff <= 47'(theta[16:0]) * 47'(DEG_PER_RAD_Q24);
         prhi1_ff <= 50'($signed(theta[35:17])) * 50'($signed({1'b0, DEG_PER_RAD_Q24}));
         th1_ff   <= theta;
         co1_ff   <= ccd_ff[CORDIC_STAGES-1];
         deg2_ff  <= (68'(prhi1_ff) <<< 17) + $signed({21'b0, prlo1_ff});
         th2_ff   <= th1_ff;
         co2_ff   <= co1_ff;
      end
   end

   // ---------------- result select, sign, saturation, zero for degenerate input
   logic signed [OUT_W-1:0] res_in;

   always_comb begin
      logic signed [67:0] r;
      logic               angle_mode;
      angle_mode = 1'b1;
      case (mode_ff)
         MODE_RAD: r = round_shift(68'(th2_ff), RAD_SH);
         MODE_DEG: r = round_shift(deg2_ff, DEG_SH);
         default: begin
            r          = round_shift(68'(co2_ff.c), RAD_SH);
            angle_mode = 1'b0;
         end
      endcase
      if (angle_mode && co2_ff.side.neg) begin
         r = -r;
      end
      if (r > OUT_MAX) begin
         r = OUT_MAX;
      end else if (r < OUT_MIN) begin
         r = OUT_MIN;
      end
      if (co2_ff.side.degen) begin
         r = '0;
      end
      res_in = r[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_value_ff <= res_in;
         rsp_degen_ff <= co2_ff.side.degen;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.angle_value = rsp_value_ff;
   assign rsp_if.degenerate  = rsp_degen_ff;

   `DHA_ASSERT(a_degen_zero, rsp_valid_ff && rsp_degen_ff |-> rsp_value_ff == '0, "degen value")
   `DHA_ASSERT(a_stall_hold, !en |=> $stable(vld_ff), "valid chain moved while stalled")
   `DHA_ASSERT(a_entry, en |=> vld_ff[0] == $past(req_if.valid), "input transfer not tracked")
   `DHA_ASSERT_ALWAYS(a_reset_clear, reset |=> vld_ff == '0 && !rsp_valid_ff, "valid after reset")

endmodule
